// File: hdl/sbx_pkg.sv
package sbx_pkg;

    localparam int DIV_STAGES = 48;
    localparam int PIPE_DEPTH = DIV_STAGES + 5;

    localparam logic signed [48:0] T_SAT   = 49'sd281474976710655;
    localparam logic signed [48:0] T_CLAMP = 49'sd65536000000;

    localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

    typedef enum logic [1:0] {
        KIND_MISS    = 2'd0,
        KIND_OUTSIDE = 2'd1,
        KIND_INSIDE  = 2'd2
    } hit_kind_t;

    typedef struct packed {
        logic q_neg;
        logic d_zero;
        logic n_neg;
    } div_flags_t;

    typedef struct packed {
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        div_flags_t  flags;
    } div_req_t;

    typedef struct packed {
        logic [31:0] rem;
        logic [47:0] dvd;
        logic [47:0] quo;
    } div_state_t;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    function automatic div_state_t div_step(input div_state_t s, input logic [31:0] d);
        div_state_t  r;
        logic [31:0] sh;
        logic [32:0] diff;
        sh    = {s.rem[30:0], s.dvd[47]};
        diff  = {1'b0, sh} - {1'b0, d};
        r.dvd = {s.dvd[46:0], 1'b0};
        if (!diff[32]) begin
            r.rem = diff[31:0];
            r.quo = {s.quo[46:0], 1'b1};
        end else begin
            r.rem = sh;
            r.quo = {s.quo[46:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: hdl/sbx_div_lane.sv
module sbx_div_lane (
    input  logic                    aclk,
    input  logic                    en,
    input  sbx_pkg::div_req_t       req,
    output logic signed [48:0]      quot
);
    import sbx_pkg::*;

    div_state_t  st_reg  [DIV_STAGES];
    div_state_t  st_next [DIV_STAGES];
    logic [31:0] dvs_reg [DIV_STAGES];
    div_flags_t  flg_reg [DIV_STAGES];

    div_state_t  init;
    logic signed [48:0] mag;

    assign init.rem = '0;
    assign init.dvd = {req.mag_n, 16'b0};
    assign init.quo = '0;

    always_comb begin
        st_next[0] = div_step(init, req.mag_d);
        for (int k = 1; k < DIV_STAGES; k++) begin
            st_next[k] = div_step(st_reg[k-1], dvs_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            st_reg[0]  <= st_next[0];
            dvs_reg[0] <= req.mag_d;
            flg_reg[0] <= req.flags;
            for (int k = 1; k < DIV_STAGES; k++) begin
                st_reg[k]  <= st_next[k];
                dvs_reg[k] <= dvs_reg[k-1];
                flg_reg[k] <= flg_reg[k-1];
            end
        end
    end

    assign mag = {1'b0, st_reg[DIV_STAGES-1].quo};

    always_comb begin
        if (flg_reg[DIV_STAGES-1].d_zero) begin
            quot = flg_reg[DIV_STAGES-1].n_neg ? -T_SAT : T_SAT;
        end else begin
            quot = flg_reg[DIV_STAGES-1].q_neg ? -mag : mag;
        end
    end

endmodule

// File: hdl/ray_box_slab_intersect.sv
// Channel | Dir | Fields (low bit up)
// s_      | in  | tdata: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 b each)
// m_      | out | tdata: hit_kind[1:0], root[37:2], zero pad to 40 b
// cfg_    | in  | box_min_x/y/z, box_max_x/y/z at index 0..5, written on cfg_wr_en
//
// One ray per cycle while m_ is not stalled: one input register, 48 radix-2 divide
// stages (six dividers side by side), then quotient register, sort, min/max
// and classify.
// aresetn clears config to the unit box and drops all valid bits.
// A stall at m_ freezes the whole pipe; s_tready falls only while m_ is full
// and not taken.
module ray_box_slab_intersect (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // hit_kind[1:0], root[37:2], pad
    input  logic         cfg_wr_en,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import sbx_pkg::*;

    logic signed [31:0] box_lo_reg [3];
    logic signed [31:0] box_hi_reg [3];

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic                  en;

    div_req_t           req_reg  [6];
    div_req_t           req_next [6];
    logic signed [48:0] quot     [6];
    logic signed [48:0] t_reg    [6];
    logic signed [48:0] lo_reg   [3];
    logic signed [48:0] hi_reg   [3];
    logic signed [48:0] entry_reg, exit_reg;
    logic signed [48:0] entry_next, exit_next;
    logic signed [48:0] e01, e2c, x01, x2c;
    hit_kind_t          kind_reg, kind_next;
    logic [35:0]        root_reg, root_next;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign m_tvalid = valid_reg[PIPE_DEPTH-1];
    assign m_tdata  = {2'b00, root_reg, kind_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                box_lo_reg[a] <= 32'sd0;
                box_hi_reg[a] <= 32'sd65536;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                REG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                REG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                REG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                REG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                REG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], s_tvalid};
        end
    end

    // lanes 0..2: lower corner per axis, lanes 3..5: upper corner
    always_comb begin
        logic signed [31:0] org;
        logic signed [31:0] dir;
        logic signed [31:0] crn;
        logic signed [32:0] n;
        for (int l = 0; l < 6; l++) begin
            org = s_tdata[(l % 3)*32 +: 32];
            dir = s_tdata[(l % 3)*32 + 96 +: 32];
            crn = (l < 3) ? box_lo_reg[l % 3] : box_hi_reg[l % 3];
            n   = 33'(crn) - 33'(org);
            req_next[l].mag_n        = n[32] ? 32'(-n) : n[31:0];
            req_next[l].mag_d        = dir[31] ? 32'(-dir) : dir;
            req_next[l].flags.q_neg  = n[32] ^ dir[31];
            req_next[l].flags.d_zero = (dir == 32'sd0);
            req_next[l].flags.n_neg  = n[32];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                req_reg[l] <= req_next[l];
            end
        end
    end

    for (genvar l = 0; l < 6; l++) begin : g_lane
        sbx_div_lane u_lane (
            .aclk (aclk),
            .en   (en),
            .req  (req_reg[l]),
            .quot (quot[l])
        );
    end

    always_comb begin
        e01        = (lo_reg[0] > lo_reg[1]) ? lo_reg[0] : lo_reg[1];
        e2c        = (lo_reg[2] > -T_CLAMP) ? lo_reg[2] : -T_CLAMP;
        entry_next = (e01 > e2c) ? e01 : e2c;
        x01        = (hi_reg[0] < hi_reg[1]) ? hi_reg[0] : hi_reg[1];
        x2c        = (hi_reg[2] < T_CLAMP) ? hi_reg[2] : T_CLAMP;
        exit_next  = (x01 < x2c) ? x01 : x2c;
    end

    always_comb begin
        if (entry_reg > exit_reg || exit_reg < 0) begin
            kind_next = KIND_MISS;
            root_next = '0;
        end else if (entry_reg < 0) begin
            kind_next = KIND_INSIDE;
            root_next = exit_reg[35:0];
        end else begin
            kind_next = KIND_OUTSIDE;
            root_next = entry_reg[35:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                t_reg[l] <= quot[l];
            end
            for (int a = 0; a < 3; a++) begin
                lo_reg[a] <= (t_reg[a] > t_reg[a+3]) ? t_reg[a+3] : t_reg[a];
                hi_reg[a] <= (t_reg[a] > t_reg[a+3]) ? t_reg[a] : t_reg[a+3];
            end
            entry_reg <= entry_next;
            exit_reg  <= exit_next;
            kind_reg  <= kind_next;
            root_reg  <= root_next;
        end
    end

endmodule
